// ===== sv/rna_pkg.sv =====
// ----------------------------------------------------------------------------
// rna_pkg: shared types and constants for the radix number to ASCII block
// Field widths, radix bounds, character codes and the cell control bundle.
// ----------------------------------------------------------------------------
package rna_pkg;

  localparam int VALUE_W = 64;
  localparam int RADIX_W = 8;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd36;

  localparam logic [CHAR_W-1:0] ASCII_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] DECIMAL_DIGITS = 8'd10;
  localparam logic [CHAR_W-1:0] BAD_CHAR       = 8'h00;

  // broadcast to every digit cell
  typedef struct packed {
    logic clr;    // start of a new number: digits and tokens cleared
    logic shift;  // digits move one cell towards the top
  } cell_ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (dw < DECIMAL_DIGITS) begin
      return ASCII_ZERO + dw;
    end
    return ASCII_UPPER_A - DECIMAL_DIGITS + dw;
  endfunction

endpackage

// ===== sv/rna_cell.sv =====
// ----------------------------------------------------------------------------
// rna_cell: one digit of the radix conversion chain
// Holds one radix digit. A bit arriving from the cell below doubles the digit
// and adds the bit; the carry is registered and goes on to the cell above in the next cycle.
// ----------------------------------------------------------------------------
module rna_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rna_pkg::cell_ctrl_t            ctrl,
  input  logic [rna_pkg::RADIX_W-1:0]    radix,
  input  logic                           tok_in,
  input  logic                           carry_in,
  input  logic [rna_pkg::DIGIT_W-1:0]    digit_in,
  output logic                           tok_out,
  output logic                           carry_out,
  output logic [rna_pkg::DIGIT_W-1:0]    digit_out
);
  import rna_pkg::*;

  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic               tok_r;
  logic               carry_r, carry_nxt;
  logic [RADIX_W-1:0] dbl;
  logic [RADIX_W-1:0] diff;

  // digit < radix <= 36, so 2*digit+1 < 2*radix and one subtract suffices
  assign dbl       = {{(RADIX_W-DIGIT_W-1){1'b0}}, digit_r, carry_in};
  assign diff      = dbl - radix;
  assign carry_nxt = (dbl >= radix);
  assign digit_nxt = carry_nxt ? diff[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= ctrl.clr ? 1'b0 : tok_in;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (ctrl.clr) begin
      digit_r <= '0;
    end else if (ctrl.shift) begin
      digit_r <= digit_in;
    end else if (tok_in) begin
      digit_r <= digit_nxt;
    end
  end

  assign tok_out   = tok_r;
  assign carry_out = carry_r;
  assign digit_out = digit_r;

endmodule

// ===== sv/radix_number_to_ascii_top.sv =====
// ----------------------------------------------------------------------------
// radix_number_to_ascii_top: unsigned 64-bit integer to ASCII digits
// Systolic binary-to-radix conversion on a row of digit cells, then the
// digits are shifted out of the top cell, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries in_value and in_radix. One
//   number is worked on at a time; in_stall is high during reset and from
//   acceptance until the last character has been loaded into the output
//   register.
//   Output channel (out_valid/out_stall) gives one transaction per
//   character: out_digit_char, out_last_digit on the final one, and
//   out_bad_radix (with a zero character, single transaction) when the
//   radix is outside 2..36.
//   Steps per number: accept, then conversion while the value's 64 bits
//   ripple up the cell row (the top cell is reached last), then the
//   digits are shifted out of the top cell, leading zeros dropped
//   without using the output. A bad radix skips the conversion.
//   A stalled receiver holds the output register and freezes the shifting of
//   digits to the output; leading zeros are still dropped. Synchronous reset
//   clears the controller, the output valid and the cell tokens; no result is pending after reset.
// ----------------------------------------------------------------------------
module radix_number_to_ascii_top #(
  parameter int DIGIT_LIMIT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rna_pkg::VALUE_W-1:0]   in_value,
  input  logic [rna_pkg::RADIX_W-1:0]   in_radix,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rna_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_last_digit,
  output logic                          out_bad_radix
);
  import rna_pkg::*;

  localparam int CONV_CYCLES = VALUE_W + DIGIT_LIMIT - 1;
  localparam int CW          = $clog2(CONV_CYCLES + 1);
  localparam int RW          = $clog2(DIGIT_LIMIT + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT, ST_BAD} state_t;

  state_t              state_r;
  logic [VALUE_W-1:0]  value_r;
  logic [RADIX_W-1:0]  radix_r;
  logic [CW-1:0]       cnt_r;
  logic [RW-1:0]       rem_r;
  logic                started_r;
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;
  logic                out_bad_r;

  logic                accept;
  logic                radix_bad;
  logic                can_load;
  logic                skip;
  logic                emit;
  logic                bad_emit;
  cell_ctrl_t          ctrl;
  logic [DIGIT_W-1:0]  top_digit;

  logic                tok_w   [DIGIT_LIMIT+1];
  logic                carry_w [DIGIT_LIMIT];
  logic [DIGIT_W-1:0]  digit_w [DIGIT_LIMIT+1];

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign radix_bad = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
  assign can_load  = !out_valid_r || !out_stall;
  assign top_digit = digit_w[DIGIT_LIMIT];
  assign skip      = (state_r == ST_EMIT) && !started_r && (top_digit == '0) &&
                     (rem_r != RW'(1));
  assign emit      = (state_r == ST_EMIT) && !skip && can_load;
  assign bad_emit  = (state_r == ST_BAD) && can_load;

  assign ctrl.clr   = accept;
  assign ctrl.shift = skip || emit;

  // MSB of the value enters the bottom cell first
  assign tok_w[0]   = (state_r == ST_CONV) && (cnt_r < CW'(VALUE_W));
  assign carry_w[0] = value_r[VALUE_W-1];
  assign digit_w[0] = '0;

  for (genvar k = 0; k < DIGIT_LIMIT; k++) begin : g_cell
    if (k < DIGIT_LIMIT - 1) begin : g_mid
      rna_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .radix     (radix_r),
        .tok_in    (tok_w[k]),
        .carry_in  (carry_w[k]),
        .digit_in  (digit_w[k]),
        .tok_out   (tok_w[k+1]),
        .carry_out (carry_w[k+1]),
        .digit_out (digit_w[k+1])
      );
    end else begin : g_top
      // carry out of the top digit is the part above radix^DIGIT_LIMIT: dropped
      rna_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .radix     (radix_r),
        .tok_in    (tok_w[k]),
        .carry_in  (carry_w[k]),
        .digit_in  (digit_w[k]),
        .tok_out   (tok_w[k+1]),
        .carry_out (),
        .digit_out (digit_w[k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rem_r       <= '0;
      started_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            value_r   <= in_value;
            radix_r   <= in_radix;
            cnt_r     <= '0;
            rem_r     <= RW'(DIGIT_LIMIT);
            started_r <= 1'b0;
            state_r   <= radix_bad ? ST_BAD : ST_CONV;
          end
        end
        ST_CONV: begin
          value_r <= value_r << 1;
          cnt_r   <= cnt_r + CW'(1);
          if (cnt_r == CW'(CONV_CYCLES - 1)) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (skip || emit) begin
            rem_r <= rem_r - RW'(1);
          end
          if (emit) begin
            started_r <= 1'b1;
            if (rem_r == RW'(1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_BAD: begin
          if (bad_emit) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (emit) begin
        out_valid_r <= 1'b1;
        out_char_r  <= digit_to_ascii(top_digit);
        out_last_r  <= (rem_r == RW'(1));
        out_bad_r   <= 1'b0;
      end else if (bad_emit) begin
        out_valid_r <= 1'b1;
        out_char_r  <= BAD_CHAR;
        out_last_r  <= 1'b1;
        out_bad_r   <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall       = !rst_n || (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;
  assign out_bad_radix  = out_bad_r;

`ifndef SYNTHESIS
  a_tok_only_conv: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[DIGIT_LIMIT] |-> (state_r == ST_CONV) || (state_r == ST_EMIT))
    else $error("conversion token left the cell row outside conversion");

  a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (rem_r != '0))
    else $error("emission running with no digits left");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (rem_r == RW'(1))) |=> (state_r == ST_IDLE) && out_valid_r && out_last_r)
    else $error("final character not marked or controller not idle");

  a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
    bad_emit |=> out_valid_r && out_bad_r && out_last_r && (out_char_r == BAD_CHAR))
    else $error("bad radix transaction malformed");

  a_digit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> !out_bad_r)
    else $error("digit transaction flagged as bad radix");
`endif

endmodule
